@@ hw/rtl/ccal_pkg.sv @@
// Shared constants and types of the contiguous cell allocator.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package ccal_pkg;

  localparam int POOL_CELLS = 8192;
  localparam int MAX_RUN    = 1024;
  localparam int ADDR_W     = $clog2(POOL_CELLS);

  // Field widths of the channels.
  localparam int CELLS_W  = 11;
  localparam int FADDR_W  = 13;
  localparam int COUNT_W  = 14;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_RUN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LAST_CELL = 3'd4;

  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_SHRINK = 1'b1;

  // Access request to the ring and used-flag store.
  typedef struct packed {
    logic [ADDR_W-1:0] nxt_raddr;
    logic [ADDR_W-1:0] prv_raddr;
    logic [ADDR_W-1:0] used_raddr;
    logic              nxt_we;
    logic [ADDR_W-1:0] nxt_waddr;
    logic [ADDR_W-1:0] nxt_wdata;
    logic              prv_we;
    logic [ADDR_W-1:0] prv_waddr;
    logic [ADDR_W-1:0] prv_wdata;
    logic              used_we;
    logic [ADDR_W-1:0] used_waddr;
    logic              used_wdata;
  } ccal_mem_req_t;

  // Registered read data, valid in the cycle after the read address.
  typedef struct packed {
    logic [ADDR_W-1:0] nxt_rdata;
    logic [ADDR_W-1:0] prv_rdata;
    logic              used_rdata;
  } ccal_mem_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ccal_if.sv @@
// Valid/ready channel interfaces for requests and results of the allocator.
// Depends on ccal_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ccal_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [ccal_pkg::CELLS_W-1:0]    run_cells;
  logic [ccal_pkg::FADDR_W-1:0]    run_address;
  logic [ccal_pkg::CELLS_W-1:0]    keep_cells;

  modport source (output valid, req_type, run_cells, run_address, keep_cells, input ready);
  modport sink (input valid, req_type, run_cells, run_address, keep_cells, output ready);
endinterface

interface ccal_out_if;
  logic                            valid;
  logic                            ready;
  logic [ccal_pkg::STATUS_W-1:0]   status;
  logic [ccal_pkg::FADDR_W-1:0]    granted_address;
  logic [ccal_pkg::COUNT_W-1:0]    in_use_count;
  logic [ccal_pkg::COUNT_W-1:0]    peak_count;

  modport source (output valid, status, granted_address, in_use_count, peak_count,
                  input ready);
  modport sink (input valid, status, granted_address, in_use_count, peak_count,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ccal_store.sv @@
// Ring link store (next and previous) and per-cell used flags of the pool.
// Each array has one write and one registered read port. Depends on ccal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccal_store (
  input  wire                     clk,
  input  wire ccal_pkg::ccal_mem_req_t req,
  output ccal_pkg::ccal_mem_rsp_t rsp
);
  import ccal_pkg::*;

  logic [ADDR_W-1:0] nxt_mem [POOL_CELLS];
  logic [ADDR_W-1:0] prv_mem [POOL_CELLS];
  logic              used_mem [POOL_CELLS];

  logic [ADDR_W-1:0] nxt_rd_r;
  logic [ADDR_W-1:0] prv_rd_r;
  logic              used_rd_r;

  always_ff @(posedge clk) begin
    if (req.nxt_we) begin
      nxt_mem[req.nxt_waddr] <= req.nxt_wdata;
    end
    nxt_rd_r <= nxt_mem[req.nxt_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.prv_we) begin
      prv_mem[req.prv_waddr] <= req.prv_wdata;
    end
    prv_rd_r <= prv_mem[req.prv_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.used_we) begin
      used_mem[req.used_waddr] <= req.used_wdata;
    end
    used_rd_r <= used_mem[req.used_raddr];
  end

  assign rsp.nxt_rdata  = nxt_rd_r;
  assign rsp.prv_rdata  = prv_rd_r;
  assign rsp.used_rdata = used_rd_r;

endmodule

`default_nettype wire

@@ hw/rtl/contiguous_cell_allocator.sv @@
// Top level of the contiguous cell allocator: request sequencer, counters,
// result register. Depends on ccal_pkg, ccal_if and ccal_store.
`timescale 1ns / 1ps
`default_nettype none

// Hands out runs of 1 to 1024 adjacent cells from an 8192-cell pool and frees or
// shrinks them; one result per request. After reset the block writes the initial
// two-cell ring (S_INIT0, S_INIT1), then takes requests one at a time; in_ch.ready
// is low while a request is in work. All link and flag accesses go through one
// registered-read port per store, so each request works one access at a time:
// a bump allocation marks its cells used in turn; a ring allocation tests the
// cells below the bump pointer (cells at or above it are not read), steps the
// ring and then unlinks the cells of the run in turn; a shrink skips its cells
// past the pool's end and frees its used cells below the bump pointer in turn.
// A finished result waits in the output register.
module contiguous_cell_allocator (
  input wire        clk,
  input wire        rst_n,
  ccal_in_if.sink   in_ch,
  ccal_out_if.source out_ch
);
  import ccal_pkg::*;

  localparam logic [4:0] S_INIT0 = 5'd0;
  localparam logic [4:0] S_INIT1 = 5'd1;
  localparam logic [4:0] S_IDLE  = 5'd2;
  localparam logic [4:0] S_START = 5'd3;
  localparam logic [4:0] S_BUMP  = 5'd4;
  localparam logic [4:0] S_MARK  = 5'd5;
  localparam logic [4:0] S_MARKD = 5'd6;
  localparam logic [4:0] S_CHK   = 5'd7;
  localparam logic [4:0] S_CHKD  = 5'd8;
  localparam logic [4:0] S_ADV   = 5'd9;
  localparam logic [4:0] S_ADVD  = 5'd10;
  localparam logic [4:0] S_LAST  = 5'd11;
  localparam logic [4:0] S_ULRD  = 5'd12;
  localparam logic [4:0] S_ULWR  = 5'd13;
  localparam logic [4:0] S_OK    = 5'd14;
  localparam logic [4:0] S_SHRD  = 5'd15;
  localparam logic [4:0] S_SHWR1 = 5'd16;
  localparam logic [4:0] S_SHWR2 = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  localparam logic [COUNT_W:0] POOL_EXT = (COUNT_W+1)'(POOL_CELLS);

  ccal_mem_req_t mreq;
  ccal_mem_rsp_t mrsp;

  ccal_store u_store (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  logic [4:0]          state_r, state_nxt;
  logic                type_r, type_nxt;
  logic [CELLS_W-1:0]  cells_r, cells_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CELLS_W-1:0]  keep_r, keep_nxt;
  logic [CELLS_W-1:0]  idx_r, idx_nxt;
  logic [CELLS_W-1:0]  cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   start_r, start_nxt;
  logic [ADDR_W-1:0]   mark_r, mark_nxt;
  logic [COUNT_W-1:0]  steps_r, steps_nxt;
  logic [ADDR_W-1:0]   pv_r, pv_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0]   grant_r, grant_nxt;
  logic [ADDR_W-1:0]   ring_ptr_r, ring_ptr_nxt;
  logic [COUNT_W-1:0]  bump_r, bump_nxt;
  logic                bump_en_r, bump_en_nxt;
  logic [COUNT_W-1:0]  used_r, used_nxt;
  logic [COUNT_W-1:0]  peak_r, peak_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_grant_r, out_grant_nxt;
  logic [COUNT_W-1:0]  out_used_r, out_used_nxt;
  logic [COUNT_W-1:0]  out_peak_r, out_peak_nxt;

  logic [COUNT_W-1:0]  shr_addr;
  logic [ADDR_W-1:0]   ul_addr;
  logic [CELLS_W-1:0]  idx_inc;
  logic [COUNT_W-1:0]  new_used;

  assign shr_addr = COUNT_W'(addr_r) + COUNT_W'(idx_r);
  assign ul_addr  = start_r + ADDR_W'(idx_r);
  assign idx_inc  = idx_r + CELLS_W'(1);
  assign new_used = used_r + COUNT_W'(cells_r);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    type_nxt     = type_r;
    cells_nxt    = cells_r;
    addr_nxt     = addr_r;
    keep_nxt     = keep_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    ptr_nxt      = ptr_r;
    start_nxt    = start_r;
    mark_nxt     = mark_r;
    steps_nxt    = steps_r;
    pv_nxt       = pv_r;
    status_nxt   = status_r;
    grant_nxt    = grant_r;
    ring_ptr_nxt = ring_ptr_r;
    bump_nxt     = bump_r;
    bump_en_nxt  = bump_en_r;
    used_nxt     = used_r;
    peak_nxt     = peak_r;

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_used_nxt   = out_used_r;
    out_peak_nxt   = out_peak_r;

    mreq            = '0;
    mreq.nxt_raddr  = ring_ptr_r;
    mreq.prv_raddr  = ring_ptr_r;
    mreq.used_raddr = ptr_r[ADDR_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT0: begin
        // cell 0 and cell 1 form the starting ring
        mreq.nxt_we     = 1'b1;
        mreq.nxt_waddr  = ADDR_W'(0);
        mreq.nxt_wdata  = ADDR_W'(1);
        mreq.prv_we     = 1'b1;
        mreq.prv_waddr  = ADDR_W'(0);
        mreq.prv_wdata  = ADDR_W'(1);
        mreq.used_we    = 1'b1;
        mreq.used_waddr = ADDR_W'(0);
        mreq.used_wdata = 1'b0;
        state_nxt       = S_INIT1;
      end
      S_INIT1: begin
        mreq.nxt_we     = 1'b1;
        mreq.nxt_waddr  = ADDR_W'(1);
        mreq.nxt_wdata  = ADDR_W'(0);
        mreq.prv_we     = 1'b1;
        mreq.prv_waddr  = ADDR_W'(1);
        mreq.prv_wdata  = ADDR_W'(0);
        mreq.used_we    = 1'b1;
        mreq.used_waddr = ADDR_W'(1);
        mreq.used_wdata = 1'b0;
        state_nxt       = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          type_nxt  = in_ch.req_type;
          cells_nxt = in_ch.run_cells;
          addr_nxt  = in_ch.run_address;
          keep_nxt  = in_ch.keep_cells;
          state_nxt = S_START;
        end
      end
      S_START: begin
        status_nxt = ST_OK;
        grant_nxt  = '0;
        if (type_r == REQ_SHRINK) begin
          idx_nxt   = keep_r;
          state_nxt = (keep_r >= cells_r) ? S_DONE : S_SHRD;
        end else if (cells_r == '0 || cells_r > CELLS_W'(MAX_RUN)) begin
          status_nxt = ST_TOO_LARGE;
          state_nxt  = S_DONE;
        end else if ({1'b0, used_r} + (COUNT_W+1)'(cells_r) > POOL_EXT) begin
          status_nxt = ST_POOL_FULL;
          state_nxt  = S_DONE;
        end else if (bump_en_r && ({1'b0, bump_r} + (COUNT_W+1)'(cells_r) <= POOL_EXT)) begin
          grant_nxt = bump_r[ADDR_W-1:0];
          idx_nxt   = '0;
          state_nxt = S_BUMP;
        end else begin
          if (cells_r == CELLS_W'(1)) begin
            bump_en_nxt = 1'b0;
          end
          state_nxt = S_MARK;
        end
      end
      S_BUMP: begin
        mreq.used_we    = 1'b1;
        mreq.used_waddr = ADDR_W'(bump_r + COUNT_W'(idx_r));
        mreq.used_wdata = 1'b1;
        idx_nxt         = idx_inc;
        if (idx_inc == cells_r) begin
          bump_nxt  = bump_r + COUNT_W'(cells_r);
          state_nxt = S_OK;
        end
      end
      S_MARK: begin
        mark_nxt  = ring_ptr_r;
        start_nxt = ring_ptr_r;
        ptr_nxt   = COUNT_W'(ring_ptr_r);
        cnt_nxt   = '0;
        steps_nxt = '0;
        state_nxt = S_MARKD;
      end
      S_MARKD: begin
        ring_ptr_nxt = mrsp.nxt_rdata;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        // cells at or above the bump pointer never count as free
        state_nxt = (ptr_r < bump_r) ? S_CHKD : S_ADV;
      end
      S_CHKD: begin
        if (!mrsp.used_rdata) begin
          if (cnt_r + CELLS_W'(1) == cells_r) begin
            state_nxt = S_LAST;
          end else begin
            cnt_nxt   = cnt_r + CELLS_W'(1);
            ptr_nxt   = ptr_r + COUNT_W'(1);
            state_nxt = S_CHK;
          end
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        start_nxt = ring_ptr_r;
        ptr_nxt   = COUNT_W'(ring_ptr_r);
        cnt_nxt   = '0;
        state_nxt = S_ADVD;
      end
      S_ADVD: begin
        ring_ptr_nxt = mrsp.nxt_rdata;
        steps_nxt    = steps_r + COUNT_W'(1);
        if (start_r == mark_r ||
            ({1'b0, steps_r} + (COUNT_W+1)'(1) > POOL_EXT)) begin
          status_nxt = ST_NO_RUN;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_LAST: begin
        if (bump_r - used_r <= COUNT_W'(cells_r)) begin
          status_nxt = ST_LAST_CELL;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_ULRD;
        end
      end
      S_ULRD: begin
        mreq.nxt_raddr = ul_addr;
        mreq.prv_raddr = ul_addr;
        state_nxt      = S_ULWR;
      end
      S_ULWR: begin
        // unlink the cell; step the ring pointer off it first
        if (ring_ptr_r == ul_addr) begin
          ring_ptr_nxt = mrsp.nxt_rdata;
        end
        mreq.nxt_we     = 1'b1;
        mreq.nxt_waddr  = mrsp.prv_rdata;
        mreq.nxt_wdata  = mrsp.nxt_rdata;
        mreq.prv_we     = 1'b1;
        mreq.prv_waddr  = mrsp.nxt_rdata;
        mreq.prv_wdata  = mrsp.prv_rdata;
        mreq.used_we    = 1'b1;
        mreq.used_waddr = ul_addr;
        mreq.used_wdata = 1'b1;
        idx_nxt         = idx_inc;
        if (idx_inc == cells_r) begin
          grant_nxt = start_r;
          state_nxt = S_OK;
        end else begin
          state_nxt = S_ULRD;
        end
      end
      S_OK: begin
        used_nxt = new_used;
        if (new_used > peak_r) begin
          peak_nxt = new_used;
        end
        state_nxt = S_DONE;
      end
      S_SHRD: begin
        mreq.used_raddr = shr_addr[ADDR_W-1:0];
        mreq.prv_raddr  = ring_ptr_r;
        if (shr_addr < COUNT_W'(POOL_CELLS)) begin
          state_nxt = S_SHWR1;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == cells_r) ? S_DONE : S_SHRD;
        end
      end
      S_SHWR1: begin
        if (shr_addr < bump_r && mrsp.used_rdata) begin
          // append before the ring pointer: own links now, neighbors next
          mreq.used_we    = 1'b1;
          mreq.used_waddr = shr_addr[ADDR_W-1:0];
          mreq.used_wdata = 1'b0;
          mreq.nxt_we     = 1'b1;
          mreq.nxt_waddr  = shr_addr[ADDR_W-1:0];
          mreq.nxt_wdata  = ring_ptr_r;
          mreq.prv_we     = 1'b1;
          mreq.prv_waddr  = shr_addr[ADDR_W-1:0];
          mreq.prv_wdata  = mrsp.prv_rdata;
          pv_nxt          = mrsp.prv_rdata;
          state_nxt       = S_SHWR2;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == cells_r) ? S_DONE : S_SHRD;
        end
      end
      S_SHWR2: begin
        mreq.prv_we    = 1'b1;
        mreq.prv_waddr = ring_ptr_r;
        mreq.prv_wdata = shr_addr[ADDR_W-1:0];
        mreq.nxt_we    = 1'b1;
        mreq.nxt_waddr = pv_r;
        mreq.nxt_wdata = shr_addr[ADDR_W-1:0];
        used_nxt       = used_r - COUNT_W'(1);
        idx_nxt        = idx_inc;
        state_nxt      = (idx_inc == cells_r) ? S_DONE : S_SHRD;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_grant_nxt  = (status_r == ST_OK) ? grant_r : '0;
          out_used_nxt   = used_r;
          out_peak_nxt   = peak_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      ring_ptr_r  <= '0;
      bump_r      <= COUNT_W'(2);
      bump_en_r   <= 1'b1;
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_ptr_r  <= ring_ptr_nxt;
      bump_r      <= bump_nxt;
      bump_en_r   <= bump_en_nxt;
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r       <= type_nxt;
    cells_r      <= cells_nxt;
    addr_r       <= addr_nxt;
    keep_r       <= keep_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    ptr_r        <= ptr_nxt;
    start_r      <= start_nxt;
    mark_r       <= mark_nxt;
    steps_r      <= steps_nxt;
    pv_r         <= pv_nxt;
    status_r     <= status_nxt;
    grant_r      <= grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_used_r   <= out_used_nxt;
    out_peak_r   <= out_peak_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.granted_address = out_grant_r;
  assign out_ch.in_use_count    = out_used_r;
  assign out_ch.peak_count      = out_peak_r;

  // allocated cells all lie below the bump pointer
  a_used_below_bump: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= bump_r) else $error("in-use count above bump pointer");

  a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= used_r) else $error("peak below in-use count");

  a_bump_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, bump_r} <= POOL_EXT) else $error("bump pointer beyond pool");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while one is in work");

endmodule

`default_nettype wire
